// File: sv/pasf_pkg.sv
// Shared types, constants and the arctangent table for the azimuth sector filter.
// No dependencies; every other file of the block refers to this package by scoped name.
package pasf_pkg;

  localparam int MAX_RANGES      = 3;
  localparam int ANGLE_FRAC_BITS = 6;
  localparam int CORDIC_STEPS    = 16;

  localparam int NUM_RANGE_REGS  = 3;
  localparam int ACC_FRAC        = 20;
  localparam int TABLE_LEN       = 24;
  localparam int TAB_IDX_W       = 5;
  localparam int STEP_W          = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  localparam int COORD_W = 24;
  localparam int TAG_W   = 20;
  localparam int BOUND_W = 15;
  localparam int CFG_W   = 15;
  localparam int ADDR_W  = 3;

  // Negated inputs reach 2^23 and the rotation gain stays below 2^25.
  localparam int XY_W  = 27;
  // 180 degrees plus the sum of the table stays well below 2^29 in Q20.
  localparam int ACC_W = 30;

  localparam logic signed [ACC_W-1:0] HALF_TURN_Q20 = ACC_W'(180 * (2 ** ACC_FRAC));
  localparam logic signed [ACC_W-1:0] ANGLE_LIM     = ACC_W'(180 * (2 ** ANGLE_FRAC_BITS));
  localparam logic signed [ACC_W-1:0] ROUND_HALF    =
    ACC_W'(2 ** (ACC_FRAC - ANGLE_FRAC_BITS - 1));
  localparam int ROUND_SHIFT = ACC_FRAC - ANGLE_FRAC_BITS;

  // Register indexes of the configuration port.
  localparam logic [ADDR_W-1:0] REG_RANGE_COUNT = 3'd0;
  localparam logic [ADDR_W-1:0] REG_RANGE0_LOW  = 3'd1;
  localparam logic [ADDR_W-1:0] REG_RANGE0_HIGH = 3'd2;
  localparam logic [ADDR_W-1:0] REG_RANGE1_LOW  = 3'd3;
  localparam logic [ADDR_W-1:0] REG_RANGE1_HIGH = 3'd4;
  localparam logic [ADDR_W-1:0] REG_RANGE2_LOW  = 3'd5;
  localparam logic [ADDR_W-1:0] REG_RANGE2_HIGH = 3'd6;

  // One word moving along the rotation chain.
  typedef struct packed {
    logic                    vld;
    logic                    zero;
    logic                    last;
    logic [TAG_W-1:0]        tag;
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [ACC_W-1:0] acc;
  } cord_t;

  // Excluded ranges as held in the configuration registers.
  typedef struct packed {
    logic [1:0]                               count;
    logic [NUM_RANGE_REGS-1:0][BOUND_W-1:0]   low;
    logic [NUM_RANGE_REGS-1:0][BOUND_W-1:0]   high;
  } range_cfg_t;

  // round(atan(2^-i) in degrees * 2^20)
  function automatic logic signed [ACC_W-1:0] atan_q20(input logic [TAB_IDX_W-1:0] i);
    logic signed [ACC_W-1:0] v;
    case (i)
      5'd0:    v = ACC_W'(47185920);
      5'd1:    v = ACC_W'(27855475);
      5'd2:    v = ACC_W'(14718068);
      5'd3:    v = ACC_W'(7471121);
      5'd4:    v = ACC_W'(3750058);
      5'd5:    v = ACC_W'(1876857);
      5'd6:    v = ACC_W'(938658);
      5'd7:    v = ACC_W'(469357);
      5'd8:    v = ACC_W'(234682);
      5'd9:    v = ACC_W'(117342);
      5'd10:   v = ACC_W'(58671);
      5'd11:   v = ACC_W'(29335);
      5'd12:   v = ACC_W'(14668);
      5'd13:   v = ACC_W'(7334);
      5'd14:   v = ACC_W'(3667);
      5'd15:   v = ACC_W'(1833);
      5'd16:   v = ACC_W'(917);
      5'd17:   v = ACC_W'(458);
      5'd18:   v = ACC_W'(229);
      5'd19:   v = ACC_W'(115);
      5'd20:   v = ACC_W'(57);
      5'd21:   v = ACC_W'(29);
      5'd22:   v = ACC_W'(14);
      5'd23:   v = ACC_W'(7);
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [ACC_W-1:0] clamp_angle(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] r;
    if (v > ANGLE_LIM) begin
      r = ANGLE_LIM;
    end else if (v < -ANGLE_LIM) begin
      r = -ANGLE_LIM;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// File: sv/point_angle_sector_filter_core.sv
// Top level of the azimuth sector filter: configuration registers, entry stage, rotation
// chain and output stage. Depends on pasf_pkg, pasf_prerot, pasf_cordic_cell, pasf_range_check.
//
// A point is taken on every cycle in which start is high; busy is always low, since the block
// is a pipeline with one rotation cell per CORDIC step and accepts one word per clock. Each
// word passes through the entry stage, one rotation cell per step and the output stage, and
// comes out for one cycle, marked by done, and points leave in the order they came in. The
// receiver cannot hold results off, so done must be sampled on every cycle. Range registers
// should be written only while no word is in flight.
module point_angle_sector_filter_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [pasf_pkg::COORD_W-1:0]  x_coord,
  input  logic signed [pasf_pkg::COORD_W-1:0]  y_coord,
  input  logic [pasf_pkg::TAG_W-1:0]           point_tag,
  input  logic                                 last_point,
  input  logic                                 cfg_wr_en,
  input  logic [pasf_pkg::ADDR_W-1:0]          cfg_addr,
  input  logic [pasf_pkg::CFG_W-1:0]           cfg_wdata,
  output logic                                 done,
  output logic                                 keep,
  output logic [pasf_pkg::TAG_W-1:0]           tag_out,
  output logic signed [pasf_pkg::BOUND_W-1:0]  azimuth,
  output logic                                 end_of_cloud
);

  pasf_pkg::range_cfg_t cfg;
  pasf_pkg::cord_t      chain [pasf_pkg::CORDIC_STEPS+1];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        pasf_pkg::REG_RANGE_COUNT: cfg.count   <= cfg_wdata[1:0];
        pasf_pkg::REG_RANGE0_LOW:  cfg.low[0]  <= cfg_wdata;
        pasf_pkg::REG_RANGE0_HIGH: cfg.high[0] <= cfg_wdata;
        pasf_pkg::REG_RANGE1_LOW:  cfg.low[1]  <= cfg_wdata;
        pasf_pkg::REG_RANGE1_HIGH: cfg.high[1] <= cfg_wdata;
        pasf_pkg::REG_RANGE2_LOW:  cfg.low[2]  <= cfg_wdata;
        pasf_pkg::REG_RANGE2_HIGH: cfg.high[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  pasf_prerot u_prerot (
    .clk        (clk),
    .rst        (rst),
    .accept     (start),
    .x_coord    (x_coord),
    .y_coord    (y_coord),
    .point_tag  (point_tag),
    .last_point (last_point),
    .out        (chain[0])
  );

  for (genvar g = 0; g < pasf_pkg::CORDIC_STEPS; g++) begin : g_cell
    pasf_cordic_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .step (pasf_pkg::STEP_W'(g)),
      .in   (chain[g]),
      .out  (chain[g+1])
    );
  end

  pasf_range_check u_check (
    .clk          (clk),
    .rst          (rst),
    .in           (chain[pasf_pkg::CORDIC_STEPS]),
    .cfg          (cfg),
    .done         (done),
    .keep         (keep),
    .tag_out      (tag_out),
    .azimuth      (azimuth),
    .end_of_cloud (end_of_cloud)
  );

endmodule

// File: sv/pasf_prerot.sv
// Entry stage: registers an accepted point, folds the left half-plane onto the right one
// and flags the origin. Depends on pasf_pkg.
module pasf_prerot (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              accept,
  input  logic signed [pasf_pkg::COORD_W-1:0] x_coord,
  input  logic signed [pasf_pkg::COORD_W-1:0] y_coord,
  input  logic [pasf_pkg::TAG_W-1:0]        point_tag,
  input  logic                              last_point,
  output pasf_pkg::cord_t                   out
);

  logic signed [pasf_pkg::XY_W-1:0] x_ext;
  logic signed [pasf_pkg::XY_W-1:0] y_ext;

  assign x_ext = pasf_pkg::XY_W'(x_coord);
  assign y_ext = pasf_pkg::XY_W'(y_coord);

  always_ff @(posedge clk) begin
    if (rst) begin
      out.vld <= 1'b0;
    end else begin
      out.vld <= accept;
    end
    out.zero <= (x_coord == '0) && (y_coord == '0);
    out.last <= last_point;
    out.tag  <= point_tag;
    if (x_coord < 0) begin
      // A half turn brings the vector into the right half-plane.
      out.x   <= -x_ext;
      out.y   <= -y_ext;
      out.acc <= (y_coord >= 0) ? pasf_pkg::HALF_TURN_Q20 : -pasf_pkg::HALF_TURN_Q20;
    end else begin
      out.x   <= x_ext;
      out.y   <= y_ext;
      out.acc <= '0;
    end
  end

endmodule

// File: sv/pasf_cordic_cell.sv
// One vectoring rotation of the CORDIC chain, registered, passing the word to its neighbour.
// The step number is a tied-off port so that every cell is the same module. Depends on pasf_pkg.
module pasf_cordic_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [pasf_pkg::STEP_W-1:0]   step,
  input  pasf_pkg::cord_t               in,
  output pasf_pkg::cord_t               out
);

  logic signed [pasf_pkg::XY_W-1:0]  dx;
  logic signed [pasf_pkg::XY_W-1:0]  dy;
  logic signed [pasf_pkg::ACC_W-1:0] da;

  // Arithmetic shifts give the floor of the division for negative values too.
  assign dx = in.y >>> step;
  assign dy = in.x >>> step;
  assign da = pasf_pkg::atan_q20(pasf_pkg::TAB_IDX_W'(step));

  always_ff @(posedge clk) begin
    if (rst) begin
      out.vld <= 1'b0;
    end else begin
      out.vld <= in.vld;
    end
    out.zero <= in.zero;
    out.last <= in.last;
    out.tag  <= in.tag;
    if (in.y >= 0) begin
      out.x   <= in.x + dx;
      out.y   <= in.y - dy;
      out.acc <= in.acc + da;
    end else begin
      out.x   <= in.x - dx;
      out.y   <= in.y + dy;
      out.acc <= in.acc - da;
    end
  end

endmodule

// File: sv/pasf_range_check.sv
// Output stage: rounds and clamps the accumulated angle, tests it against the excluded
// ranges and registers the result word. Depends on pasf_pkg.
module pasf_range_check (
  input  logic                               clk,
  input  logic                               rst,
  input  pasf_pkg::cord_t                    in,
  input  pasf_pkg::range_cfg_t               cfg,
  output logic                               done,
  output logic                               keep,
  output logic [pasf_pkg::TAG_W-1:0]         tag_out,
  output logic signed [pasf_pkg::BOUND_W-1:0] azimuth,
  output logic                               end_of_cloud
);

  logic signed [pasf_pkg::ACC_W-1:0] rounded;
  logic signed [pasf_pkg::ACC_W-1:0] angle;
  logic signed [pasf_pkg::ACC_W-1:0] lo [pasf_pkg::MAX_RANGES];
  logic signed [pasf_pkg::ACC_W-1:0] hi [pasf_pkg::MAX_RANGES];
  logic                              drop;

  assign rounded = (in.acc + pasf_pkg::ROUND_HALF) >>> pasf_pkg::ROUND_SHIFT;

  always_comb begin
    angle = in.zero ? '0 : pasf_pkg::clamp_angle(rounded);
    drop  = 1'b0;
    for (int k = 0; k < pasf_pkg::MAX_RANGES; k++) begin
      lo[k] = pasf_pkg::clamp_angle(pasf_pkg::ACC_W'($signed(cfg.low[k])));
      hi[k] = pasf_pkg::clamp_angle(pasf_pkg::ACC_W'($signed(cfg.high[k])));
      if ((2'(k) < cfg.count) && (angle >= lo[k]) && (angle <= hi[k])) begin
        drop = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in.vld;
    end
    keep         <= ~drop;
    tag_out      <= in.tag;
    azimuth      <= angle[pasf_pkg::BOUND_W-1:0];
    end_of_cloud <= in.last;
  end

endmodule
